### sv/kvls_pkg.sv
// Shared types and constants for the key/value line splitter.
package kvls_pkg;

    localparam int KEY_ROOM_DEF   = 16;
    localparam int VALUE_ROOM_DEF = 32;

    localparam logic [7:0] NEWLINE_BYTE = 8'd10;
    localparam logic [7:0] COLON_BYTE   = 8'd58;

    typedef enum logic [2:0] {
        KIND_KEY      = 3'd0,
        KIND_VALUE    = 3'd1,
        KIND_DONE     = 3'd2,
        KIND_NODELIM  = 3'd3,
        KIND_OVERFLOW = 3'd4
    } kind_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_FETCH,
        ST_LOAD
    } state_t;

    typedef enum logic [1:0] {
        SEL_MEM,
        SEL_DONE,
        SEL_NODELIM,
        SEL_OVERFLOW
    } out_sel_t;

    typedef struct packed {
        logic     wr_en;
        logic     clr_line;
        logic     rd_en;
        logic     idx_clr;
        logic     idx_inc;
        logic     out_load;
        out_sel_t out_sel;
    } dp_cmd_t;

    typedef struct packed {
        logic is_newline;
        logic full;
        logic found;
        logic idx_at_fill;
        logic idx_at_colon;
        logic slot_free;
    } dp_status_t;

endpackage

### sv/key_value_line_splitter_core.sv
// Top level of the key/value line splitter: controller, datapath and checks.
//
// Received bytes enter on the input channel (in_valid, in_stall, rx_byte), one
// request per byte. Ordinary bytes are stored in the line buffer. A newline
// flushes the line: every key byte before the first colon comes out with kind
// KEY, every byte after it with kind VALUE, and a DONE marker with last set
// closes the run. For each character the flush does a registered read of the
// single-port line buffer, then a load of the output register; the colon
// itself is skipped without a read, and the marker is loaded last. A newline
// with no colon in the line gives one NODELIM result, and a non-newline byte
// that arrives on a full buffer gives one OVERFLOW result and empties the
// buffer; both are valid the cycle after the request.
// Results leave through an output register on (out_valid, out_stall, kind,
// char_out, last). While the receiver stalls, that register holds its result
// and the flush pauses; new bytes are taken only between flushes and only when
// the output register is free or being emptied in the same cycle.
// Reset empties the buffer and the output register; no clearing pass is run.
module key_value_line_splitter_core #(
    parameter int KEY_ROOM   = kvls_pkg::KEY_ROOM_DEF,
    parameter int VALUE_ROOM = kvls_pkg::VALUE_ROOM_DEF
) (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            in_valid,
    output logic            in_stall,
    input  logic [7:0]      rx_byte,
    output logic            out_valid,
    input  logic            out_stall,
    output kvls_pkg::kind_t kind,
    output logic [7:0]      char_out,
    output logic            last
);
    import kvls_pkg::*;

    // Command and status groups that join the controller and the datapath.
    dp_cmd_t    cmd;
    dp_status_t status;

    kvls_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_stall (in_stall),
        .status   (status),
        .cmd      (cmd)
    );

    kvls_datapath #(
        .KEY_ROOM   (KEY_ROOM),
        .VALUE_ROOM (VALUE_ROOM)
    ) u_datapath (
        .clk       (clk),
        .rst_n     (rst_n),
        .rx_byte   (rx_byte),
        .cmd       (cmd),
        .status    (status),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .kind      (kind),
        .char_out  (char_out),
        .last      (last)
    );

    // A byte is only taken when an error result could be placed at once.
    a_accept_has_slot: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && !in_stall) |-> status.slot_free)
        else $error("request accepted while the output register is busy");

    // A result is never loaded over one that the receiver has not taken.
    a_load_has_slot: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.out_load |-> status.slot_free)
        else $error("output register overwritten");

    // The line buffer is never written past its end.
    a_no_write_full: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.wr_en |-> !status.full)
        else $error("write into a full line buffer");

    // The delimiting colon is skipped and never read out.
    a_colon_skipped: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.rd_en |-> (!status.idx_at_colon && !status.idx_at_fill))
        else $error("read of the colon or past the fill count");

endmodule

### sv/kvls_ctrl.sv
// Sequencing state machine for the key/value line splitter.
module kvls_ctrl (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 in_valid,
    output logic                 in_stall,
    input  kvls_pkg::dp_status_t status,
    output kvls_pkg::dp_cmd_t    cmd
);
    import kvls_pkg::*;

    state_t state_reg;
    state_t state_next;
    logic   accept;

    assign accept   = (state_reg == ST_IDLE) && in_valid && status.slot_free;
    assign in_stall = !((state_reg == ST_IDLE) && status.slot_free);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (accept && status.is_newline && status.found)
                begin
                    state_next = ST_FETCH;
                end
            end
            ST_FETCH:
            begin
                if (status.idx_at_fill)
                begin
                    if (status.slot_free)
                    begin
                        state_next = ST_IDLE;
                    end
                end
                else if (!status.idx_at_colon)
                begin
                    state_next = ST_LOAD;
                end
            end
            ST_LOAD:
            begin
                if (status.slot_free)
                begin
                    state_next = ST_FETCH;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_comb
    begin
        cmd = '0;
        cmd.out_sel = SEL_MEM;
        case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    if (status.is_newline)
                    begin
                        if (status.found)
                        begin
                            cmd.idx_clr = 1'b1;
                        end
                        else
                        begin
                            cmd.out_load = 1'b1;
                            cmd.out_sel  = SEL_NODELIM;
                            cmd.clr_line = 1'b1;
                        end
                    end
                    else if (status.full)
                    begin
                        cmd.out_load = 1'b1;
                        cmd.out_sel  = SEL_OVERFLOW;
                        cmd.clr_line = 1'b1;
                    end
                    else
                    begin
                        cmd.wr_en = 1'b1;
                    end
                end
            end
            ST_FETCH:
            begin
                if (status.idx_at_fill)
                begin
                    if (status.slot_free)
                    begin
                        cmd.out_load = 1'b1;
                        cmd.out_sel  = SEL_DONE;
                        cmd.clr_line = 1'b1;
                    end
                end
                else if (status.idx_at_colon)
                begin
                    cmd.idx_inc = 1'b1;
                end
                else
                begin
                    cmd.rd_en = 1'b1;
                end
            end
            ST_LOAD:
            begin
                if (status.slot_free)
                begin
                    cmd.out_load = 1'b1;
                    cmd.out_sel  = SEL_MEM;
                    cmd.idx_inc  = 1'b1;
                end
            end
            default:
            begin
                cmd = '0;
            end
        endcase
    end

endmodule

### sv/kvls_datapath.sv
// Line buffer, colon tracking, read index and output register.
module kvls_datapath #(
    parameter int KEY_ROOM   = kvls_pkg::KEY_ROOM_DEF,
    parameter int VALUE_ROOM = kvls_pkg::VALUE_ROOM_DEF
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic [7:0]           rx_byte,
    input  kvls_pkg::dp_cmd_t    cmd,
    output kvls_pkg::dp_status_t status,
    output logic                 out_valid,
    input  logic                 out_stall,
    output kvls_pkg::kind_t      kind,
    output logic [7:0]           char_out,
    output logic                 last
);
    import kvls_pkg::*;

    localparam int LINE_ROOM = KEY_ROOM + VALUE_ROOM;
    localparam int AW        = $clog2(LINE_ROOM);
    localparam int CW        = $clog2(LINE_ROOM + 1);

    logic [7:0]    line_mem [LINE_ROOM];
    logic [7:0]    rd_data_reg;
    logic [CW-1:0] fill_reg;
    logic [CW-1:0] colon_at_reg;
    logic          found_reg;
    logic [CW-1:0] rd_idx_reg;
    logic          out_valid_reg;
    kind_t         kind_reg;
    logic [7:0]    char_reg;
    logic          last_reg;

    assign status.is_newline   = (rx_byte == NEWLINE_BYTE);
    assign status.full         = (fill_reg == CW'(LINE_ROOM));
    assign status.found        = found_reg;
    assign status.idx_at_fill  = (rd_idx_reg == fill_reg);
    assign status.idx_at_colon = (rd_idx_reg == colon_at_reg);
    assign status.slot_free    = !out_valid_reg || !out_stall;

    always_ff @(posedge clk)
    begin
        if (cmd.wr_en)
        begin
            line_mem[fill_reg[AW-1:0]] <= rx_byte;
        end
        if (cmd.rd_en)
        begin
            rd_data_reg <= line_mem[rd_idx_reg[AW-1:0]];
        end
    end

    // The first colon position is captured as the line is written.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fill_reg     <= '0;
            found_reg    <= 1'b0;
            colon_at_reg <= '0;
            rd_idx_reg   <= '0;
        end
        else
        begin
            if (cmd.clr_line)
            begin
                fill_reg  <= '0;
                found_reg <= 1'b0;
            end
            else if (cmd.wr_en)
            begin
                fill_reg <= fill_reg + CW'(1);
                if ((rx_byte == COLON_BYTE) && !found_reg)
                begin
                    found_reg    <= 1'b1;
                    colon_at_reg <= fill_reg;
                end
            end
            if (cmd.idx_clr)
            begin
                rd_idx_reg <= '0;
            end
            else if (cmd.idx_inc)
            begin
                rd_idx_reg <= rd_idx_reg + CW'(1);
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (cmd.out_load)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (!out_stall)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.out_load)
        begin
            case (cmd.out_sel)
                SEL_MEM:
                begin
                    kind_reg <= (rd_idx_reg < colon_at_reg) ? KIND_KEY : KIND_VALUE;
                    char_reg <= rd_data_reg;
                    last_reg <= 1'b0;
                end
                SEL_DONE:
                begin
                    kind_reg <= KIND_DONE;
                    char_reg <= 8'd0;
                    last_reg <= 1'b1;
                end
                SEL_NODELIM:
                begin
                    kind_reg <= KIND_NODELIM;
                    char_reg <= 8'd0;
                    last_reg <= 1'b1;
                end
                default:
                begin
                    kind_reg <= KIND_OVERFLOW;
                    char_reg <= 8'd0;
                    last_reg <= 1'b1;
                end
            endcase
        end
    end

    assign out_valid = out_valid_reg;
    assign kind      = kind_reg;
    assign char_out  = char_reg;
    assign last      = last_reg;

endmodule

### tb/sv/tb_top.sv
// Self-checking testbench for the key/value line splitter, with its own line model.
`timescale 1ns / 100ps

module tb_top;

    import kvls_pkg::*;

    localparam int LINE_ROOM  = KEY_ROOM_DEF + VALUE_ROOM_DEF;
    localparam int RAND_ITEMS = 6;

    // One expected result of a line flush or an error.
    typedef struct packed {
        kind_t      kind;
        logic [7:0] ch;
        logic       last;
    } split_result_t;

    logic       clk       = 1'b0;
    logic       rst_n     = 1'b0;
    logic       in_valid  = 1'b0;
    logic       in_stall;
    logic [7:0] rx_byte   = 8'h00;
    logic       out_valid;
    logic       out_stall = 1'b0;
    kind_t      kind;
    logic [7:0] char_out;
    logic       last;

    // Our own copy of the line buffer, updated on every accepted request.
    logic [7:0]    line_buf [LINE_ROOM];
    int unsigned   line_fill = 0;
    split_result_t expected_q [$];
    split_result_t want;

    int error_count     = 0;
    int bytes_sent      = 0;
    int results_checked = 0;
    int lines_flushed   = 0;
    int overflow_seen   = 0;
    int nodelim_seen    = 0;

    // Chance in percent of starting an idle burst, per side.
    int gap_chance   = 0;
    int stall_chance = 0;
    int stall_left   = 0;

    key_value_line_splitter_core i_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .rx_byte   (rx_byte),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .kind      (kind),
        .char_out  (char_out),
        .last      (last)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    function automatic void push_result(kind_t k, logic [7:0] ch, logic lst);
        split_result_t r;
        r.kind = k;
        r.ch   = ch;
        r.last = lst;
        expected_q.push_back(r);
    endfunction

    // Applies one received byte to the line model and queues what it should produce.
    function automatic void predict_byte(logic [7:0] b);
        int  colon_pos;
        bit  found;
        colon_pos = 0;
        found     = 1'b0;
        if (b != NEWLINE_BYTE)
        begin
            // A full buffer refuses the byte, reports overflow and starts over.
            if (line_fill >= LINE_ROOM)
            begin
                push_result(KIND_OVERFLOW, 8'h00, 1'b1);
                overflow_seen++;
                line_fill = 0;
            end
            else
            begin
                line_buf[line_fill] = b;
                line_fill++;
            end
            return;
        end
        for (int i = 0; i < line_fill; i++)
        begin
            if (!found && line_buf[i] == COLON_BYTE)
            begin
                colon_pos = i;
                found     = 1'b1;
            end
        end
        if (!found)
        begin
            push_result(KIND_NODELIM, 8'h00, 1'b1);
            nodelim_seen++;
        end
        else
        begin
            for (int i = 0; i < colon_pos; i++)
                push_result(KIND_KEY, line_buf[i], 1'b0);
            for (int i = colon_pos + 1; i < line_fill; i++)
                push_result(KIND_VALUE, line_buf[i], 1'b0);
            push_result(KIND_DONE, 8'h00, 1'b1);
            lines_flushed++;
        end
        line_fill = 0;
    endfunction

    task automatic report_mismatch(input string field, input logic [7:0] got,
                                   input logic [7:0] exp_val);
        $display("ERROR at %0t ns: result %0d, %s: got %0h, expected %0h",
                 $time, results_checked, field, got, exp_val);
        error_count++;
    endtask

    // Sends one request, with an optional idle burst in front of it. The task
    // returns right after the accepting edge with valid still high, so a
    // following call can keep the request stream gapless.
    task automatic send_byte(input logic [7:0] b);
        int gap;
        if ($urandom_range(0, 99) < gap_chance)
        begin
            gap = $urandom_range(1, 14);
            @(negedge clk);
            in_valid <= 1'b0;
            repeat (gap - 1) @(negedge clk);
        end
        @(negedge clk);
        in_valid <= 1'b1;
        rx_byte  <= b;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        predict_byte(b);
        bytes_sent++;
    endtask

    task automatic send_text(input string s);
        for (int i = 0; i < s.len(); i++)
            send_byte(s[i]);
    endtask

    // Random character that is never a newline, and never a colon if asked.
    function automatic logic [7:0] pick_char(bit no_colon);
        logic [7:0] c;
        c = NEWLINE_BYTE;
        while (c == NEWLINE_BYTE || (no_colon && c == COLON_BYTE))
            c = 8'($urandom_range(0, 255));
        return c;
    endfunction

    // Sends nbytes characters with the first colon at colon_idx (none if
    // negative); characters after the colon may hold further colons.
    task automatic send_line(input int nbytes, input int colon_idx, input bit with_nl);
        for (int i = 0; i < nbytes; i++)
        begin
            if (i == colon_idx)
                send_byte(COLON_BYTE);
            else
                send_byte(pick_char(colon_idx < 0 || i < colon_idx));
        end
        if (with_nl)
            send_byte(NEWLINE_BYTE);
    endtask

    // Drops valid after the last request and waits for every queued result.
    task automatic wait_drained(input int settle);
        @(negedge clk);
        in_valid <= 1'b0;
        while (expected_q.size() != 0)
            @(posedge clk);
        repeat (settle) @(posedge clk);
    endtask

    // Short lines covering the key, value, done and no-colon results and the corner cases of the split.
    task automatic test_directed_lines;
        gap_chance   = 30;
        stall_chance = 30;
        send_byte(NEWLINE_BYTE);     // An empty line has no colon.
        send_text("abc\n");          // No colon at all.
        send_text(":v\n");           // Empty key.
        send_text("k:\n");           // Empty value.
        send_text("a:b:c\n");        // Only the first colon splits.
        send_byte(8'h00);            // Zero and all-ones characters pass through.
        send_byte(COLON_BYTE);
        send_byte(8'hFF);
        send_byte(8'h00);
        send_byte(NEWLINE_BYTE);
        send_text(":\n");            // Key and value both empty.
        wait_drained(4);
    endtask

    // A full line flushed by a newline, then a full buffer that one more byte overflows.
    task automatic test_full_buffer;
        gap_chance   = 20;
        stall_chance = 25;
        send_line(LINE_ROOM, LINE_ROOM - 1, 1'b1);   // Longest possible key.
        send_line(LINE_ROOM, $urandom_range(0, LINE_ROOM - 1), 1'b0);
        send_byte(pick_char(1'b0));                  // Overflows and empties the buffer.
        wait_drained(4);
    endtask

    // Short lines with random content, plus stray bytes and unfinished lines
    // that run into the next one.
    task automatic test_random_traffic;
        int start;
        int len;
        int pick;
        start = bytes_sent;
        while (bytes_sent - start < RAND_ITEMS)
        begin
            // Each line picks its own idling, so some stretches run without gaps.
            gap_chance   = ($urandom_range(0, 2) == 0) ? 0 : 25;
            stall_chance = ($urandom_range(0, 2) == 0) ? 0 : 25;
            len  = $urandom_range(0, 6);
            pick = $urandom_range(0, 9);
            if (pick <= 6)
                send_line(len, (len > 0) ? $urandom_range(0, len - 1) : -1, 1'b1);
            else if (pick == 7)
                send_line(len, -1, 1'b1);
            else if (pick == 8)
                send_byte(8'($urandom_range(0, 255)));
            else
                send_line(len, (len > 0) ? $urandom_range(0, len - 1) : -1, 1'b0);
        end
        send_byte(NEWLINE_BYTE);
        wait_drained(4);
    endtask

    // Closing stretch with no idling on either side: back-to-back requests
    // and a receiver that never stalls.
    task automatic test_full_rate;
        int len;
        gap_chance   = 0;
        stall_chance = 0;
        // Let a receiver stall burst that is still running finish first.
        while (stall_left != 0 || out_stall)
            @(posedge clk);
        for (int n = 0; n < 2; n++)
        begin
            len = $urandom_range(1, 4);
            send_line(len, $urandom_range(0, len - 1), 1'b1);
        end
        wait_drained(20);
    endtask

    // Receiver stall: bursts started at the given chance.
    always @(negedge clk)
    begin
        if (stall_left > 0)
        begin
            stall_left <= stall_left - 1;
            out_stall  <= 1'b1;
        end
        else if ($urandom_range(0, 99) < stall_chance)
        begin
            stall_left <= $urandom_range(0, 13);
            out_stall  <= 1'b1;
        end
        else
            out_stall <= 1'b0;
    end

    // Every result taken at a rising edge is checked against the oldest expectation.
    always @(posedge clk)
    begin
        if (rst_n && out_valid && !out_stall)
        begin
            if (expected_q.size() == 0)
                report_mismatch("unexpected result, kind", {5'd0, kind}, 8'h00);
            else
            begin
                want = expected_q.pop_front();
                if (kind !== want.kind)
                    report_mismatch("kind", {5'd0, kind}, {5'd0, want.kind});
                if (char_out !== want.ch)
                    report_mismatch("char_out", char_out, want.ch);
                if (last !== want.last)
                    report_mismatch("last", {7'd0, last}, {7'd0, want.last});
            end
            results_checked++;
        end
    end

    initial
    begin
        repeat (9) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        test_directed_lines;
        test_full_buffer;
        test_random_traffic;
        test_full_rate;

        $display("Sent %0d bytes; checked %0d results from %0d split lines,",
                 bytes_sent, results_checked, lines_flushed);
        $display("%0d lines without a colon and %0d buffer overflows; %0d mismatches.",
                 nodelim_seen, overflow_seen, error_count);
        if (error_count == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end

    // Watchdog: far beyond the slowest correct run, even with maximal stalls.
    initial
    begin
        #5_000_000;
        $display("Timeout with %0d results still expected.", expected_q.size());
        $display("*** FAILED ***");
        $finish;
    end

endmodule

### filelist.f
sv/kvls_pkg.sv
sv/kvls_ctrl.sv
sv/kvls_datapath.sv
sv/key_value_line_splitter_core.sv
tb/sv/tb_top.sv
